// File: rtl/pfl_pkg.sv
// shared types and codes for the pareto front list
package pfl_pkg;
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DOMINATED = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_POPPED    = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    localparam int ENTRY_W = 72;

    typedef struct packed {
        logic        operation;
        logic [31:0] new_time;
        logic [31:0] new_cost;
        logic [7:0]  new_origin;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_time;
        logic [31:0] out_cost;
        logic [7:0]  out_origin;
        logic [6:0]  entry_count;
    } out_item_t;

    typedef struct packed {
        logic [31:0] t;
        logic [31:0] c;
        logic [7:0]  o;
    } entry_t;
endpackage

// File: rtl/pfl_ram.sv
// generic single-port-write, single-read synchronous ram
module pfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/pareto_front_list_top.sv
// pareto front list top level: sequencer around one entry ram
// Each item is processed alone. A pop registers the last entry as its result via S_POP. An insert
// scans the list from the start in the entry ram, one read per cycle (search for the position,
// then the dominated run), then moves the tail with one read and one write per entry; when
// nothing is removed the tail is shifted up from the end and the new entry is written last.
// Inserts are bound by the single read port of the entry ram. The result sits in an output
// register; the next item is taken the cycle after it has been delivered.
module pareto_front_list_top
    import pfl_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_MOVE  = 3'd3;
    localparam logic [2:0] S_POP   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_PUT   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;   // address being read (issued last cycle)
    logic [CW-1:0] p_reg, p_next;
    logic [CW-1:0] w_reg, w_next;       // write pointer while the tail moves
    logic          prev_ok_reg, prev_ok_next; // previous entry cost >= c
    in_item_t      item_reg, item_next;
    out_item_t     res_reg, res_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    entry_t        wdata, rd;
    logic [ENTRY_W-1:0] rdata_raw;

    assign rd = entry_t'(rdata_raw);

    pfl_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = res_reg;

    function automatic out_item_t mk(input logic [2:0] s, input logic [CW-1:0] n);
        out_item_t r;
        r = '0;
        r.status = s;
        r.entry_count = 7'(n);
        return r;
    endfunction

    always_comb
    begin
        logic [CW-1:0] removed;
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        p_next       = p_reg;
        w_next       = w_reg;
        prev_ok_next = prev_ok_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        we           = 1'b0;
        waddr        = AW'(w_reg);
        wdata        = rd;
        raddr        = AW'(idx_reg);
        removed      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                    if (in_data.operation == OP_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            res_next   = mk(ST_EMPTY, count_reg);
                            state_next = S_OUT;
                        end
                        else
                        begin
                            raddr      = AW'(count_reg - 1'b1);
                            state_next = S_POP;
                        end
                    end
                    else
                    begin
                        raddr        = '0;
                        idx_next     = '0;
                        prev_ok_next = 1'b0;
                        state_next   = S_SRCH;
                    end
                end
            end
            S_POP:
            begin
                res_next = mk(ST_POPPED, count_reg - 1'b1);
                res_next.out_time   = rd.t;
                res_next.out_cost   = rd.c;
                res_next.out_origin = rd.o;
                count_next = count_reg - 1'b1;
                state_next = S_OUT;
            end
            S_SRCH:
            begin
                if (idx_reg < count_reg && rd.t < item_reg.new_time)
                begin
                    prev_ok_next = (rd.c >= item_reg.new_cost);
                    idx_next     = idx_reg + 1'b1;
                    raddr        = AW'(idx_reg + 1'b1);
                end
                else if (prev_ok_reg || (idx_reg < count_reg
                         && rd.t == item_reg.new_time && rd.c >= item_reg.new_cost))
                begin
                    res_next   = mk(ST_DOMINATED, count_reg);
                    state_next = S_OUT;
                end
                else
                begin
                    p_next     = idx_reg;
                    raddr      = AW'(idx_reg);
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (idx_reg < count_reg && rd.c <= item_reg.new_cost)
                begin
                    idx_next = idx_reg + 1'b1;
                    raddr    = AW'(idx_reg + 1'b1);
                end
                else
                begin
                    removed = idx_reg - p_reg;
                    if (count_reg - removed >= CW'(CAPACITY))
                    begin
                        res_next   = mk(ST_FULL, count_reg);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        count_next = count_reg - removed + 1'b1;
                        res_next   = mk(ST_INSERTED, count_reg - removed + 1'b1);
                        if (idx_reg == p_reg && idx_reg < count_reg)
                        begin
                            // no removal: shift tail up by one from the end, new entry last
                            w_next     = count_reg;
                            idx_next   = count_reg - 1'b1;
                            raddr      = AW'(count_reg - 1'b1);
                            state_next = S_MOVE;
                        end
                        else
                        begin
                            we      = 1'b1;
                            waddr   = AW'(p_reg);
                            wdata.t = item_reg.new_time;
                            wdata.c = item_reg.new_cost;
                            wdata.o = item_reg.new_origin;
                            w_next  = p_reg + 1'b1;
                            if (idx_reg != p_reg && idx_reg < count_reg
                                && idx_reg != p_reg + 1'b1)
                            begin
                                state_next = S_MOVE;
                            end
                            else
                            begin
                                // exactly one removed or empty tail: nothing moves
                                state_next = S_OUT;
                            end
                        end
                    end
                end
            end
            S_MOVE:
            begin
                we    = 1'b1;
                waddr = AW'(w_reg);
                wdata = rd;
                if (w_reg > idx_reg)
                begin
                    // upward shift, walking down
                    if (idx_reg == p_reg)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                        w_next   = w_reg - 1'b1;
                        raddr    = AW'(idx_reg - 1'b1);
                    end
                end
                else
                begin
                    if (idx_reg + 1'b1 >= count_reg + (idx_reg - w_reg))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        w_next   = w_reg + 1'b1;
                        raddr    = AW'(idx_reg + 1'b1);
                    end
                end
            end
            S_PUT:
            begin
                we         = 1'b1;
                waddr      = AW'(p_reg);
                wdata.t    = item_reg.new_time;
                wdata.c    = item_reg.new_cost;
                wdata.o    = item_reg.new_origin;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        p_reg       <= p_next;
        w_reg       <= w_next;
        prev_ok_reg <= prev_ok_next;
        item_reg    <= item_next;
        res_reg     <= res_next;
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY)) else $error("count above capacity");
    a_in_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(res_reg)) else $error("result changed");
    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |=> $stable(count_reg) || state_reg != S_IDLE)
        else $error("count moved while idle");
`endif
endmodule
